FILE: design/bba_pkg.sv
// Shared types, codes and constants for the bitmap block allocator.
package bba_pkg;

  localparam int IdxW           = 6;
  localparam int OffW           = 12;
  localparam int FieldW         = 16;
  localparam int MapW           = 64;
  localparam int RecipW         = 17;
  localparam int DefBlockBytes  = 64;
  localparam int DefNumBlocks   = 64;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NULL       = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_RANGE      = 3'd4,
    ST_NOT_ALLOC  = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [FieldW-1:0] free_offset;
    logic                     range_present;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] block_index;
    logic [OffW-1:0] start_offset;
    logic [OffW-1:0] end_offset;
  } res_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } alloc_res_t;

  typedef struct packed {
    status_e         status;
    logic            clr;
    logic [IdxW-1:0] idx;
  } free_res_t;

endpackage

FILE: design/bba_ffs.sv
// Lowest set bit finder over the free-block map.
module bba_ffs
  import bba_pkg::*;
(
  input  logic [MapW-1:0] avail_i,
  output alloc_res_t      res_o
);

  logic [MapW-1:0] low;
  logic [IdxW-1:0] idx;

  assign low = avail_i & (~avail_i + MapW'(1));

  always_comb begin
    idx = '0;
    for (int b = 0; b < IdxW; b++) begin
      for (int i = 0; i < MapW; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx[b] = idx[b] | low[i];
        end
      end
    end
  end

  assign res_o.found = |avail_i;
  assign res_o.idx   = idx;

endmodule

FILE: design/bba_free_chk.sv
// Free request checks: presence, alignment, range and allocation.
module bba_free_chk
  import bba_pkg::*;
#(
  parameter int BLOCK_BYTES = DefBlockBytes,
  parameter int NUM_BLOCKS  = DefNumBlocks
) (
  input  logic signed [FieldW-1:0] offset_i,
  input  logic                     present_i,
  input  logic [MapW-1:0]          map_i,
  output free_res_t                res_o
);

  localparam int Shift = FieldW + $clog2(BLOCK_BYTES);
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
  localparam int ProdW = FieldW + RecipW;
  localparam int BackW = FieldW + 13;

  logic              neg;
  logic [FieldW-1:0] mag;
  logic [ProdW-1:0]  prod;
  logic [FieldW-1:0] quo;
  logic [BackW-1:0]  back;
  logic              misaligned;
  logic              out_of_range;

  assign neg  = offset_i[FieldW-1];
  assign mag  = neg ? (~offset_i + FieldW'(1)) : offset_i;
  // quotient by reciprocal multiply, exact for 16-bit magnitudes
  assign prod = ProdW'(mag) * ProdW'(Recip);
  assign quo  = FieldW'(prod >> Shift);
  assign back = BackW'(quo) * BackW'(BLOCK_BYTES);

  assign misaligned   = BackW'(mag) != back;
  assign out_of_range = neg || (quo >= FieldW'(NUM_BLOCKS));

  always_comb begin
    res_o.status = ST_OK;
    res_o.clr    = 1'b0;
    res_o.idx    = quo[IdxW-1:0];
    priority if (!present_i) begin
      res_o.status = ST_NULL;
    end else if (misaligned) begin
      res_o.status = ST_MISALIGNED;
    end else if (out_of_range) begin
      res_o.status = ST_RANGE;
    end else if (!map_i[quo[IdxW-1:0]]) begin
      res_o.status = ST_NOT_ALLOC;
    end else begin
      res_o.clr = 1'b1;
    end
  end

endmodule

FILE: design/bitmap_block_allocator_core.sv
// Top level of the bitmap fixed-block pool allocator.
//
// Usage:
//   Request channel: a transaction is taken at a rising edge with start high
//   and busy low. busy stays low, so one request can be taken every cycle.
//   req_i carries the command (allocate or free), the free offset and the
//   range-present flag.
//   Result channel: res_valid_o is high for exactly one cycle with res_o
//   holding the status, block index and byte offsets of the block.
//   A request taken at a rising edge is registered in the request stage,
//   evaluated against the used map in the next cycle, and its result is
//   registered in the result stage and shown on res_o.
//   Throughput: one request per cycle; the map update and the result share
//   one register stage, so back-to-back requests see each other's effect.
//   Reset: rst_ni low clears the used map (every block free) and drops all
//   pending transactions. The receiver cannot stall; results are never held.
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int BLOCK_BYTES = DefBlockBytes,
  parameter int NUM_BLOCKS  = DefNumBlocks
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam logic [OffW-1:0] EndAdd = OffW'(BLOCK_BYTES - 1);
  localparam int              MulW   = IdxW + 13;

  req_t                  req_q;
  logic                  req_vld_q;
  res_t                  res_q, res_d;
  logic                  res_vld_q;
  logic [NUM_BLOCKS-1:0] used_q, used_d;

  logic [MapW-1:0] avail;
  logic [MapW-1:0] map64;
  alloc_res_t      alloc_res;
  free_res_t       free_res;
  logic [MulW-1:0] start_full;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // blocks at or above NUM_BLOCKS never show as free
  assign avail = MapW'(used_q ^ {NUM_BLOCKS{1'b1}});
  assign map64 = MapW'(used_q);

  bba_ffs u_ffs (
    .avail_i (avail),
    .res_o   (alloc_res)
  );

  bba_free_chk #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_free_chk (
    .offset_i  (req_q.free_offset),
    .present_i (req_q.range_present),
    .map_i     (map64),
    .res_o     (free_res)
  );

  assign start_full = MulW'(alloc_res.idx) * MulW'(BLOCK_BYTES);

  always_comb begin
    res_d        = '0;
    res_d.status = ST_OK;
    used_d       = used_q;
    unique case (req_q.command)
      CMD_ALLOC: begin
        if (alloc_res.found) begin
          res_d.block_index  = alloc_res.idx;
          res_d.start_offset = start_full[OffW-1:0];
          res_d.end_offset   = start_full[OffW-1:0] + EndAdd;
          used_d = used_q | NUM_BLOCKS'(MapW'(1) << alloc_res.idx);
        end else begin
          res_d.status = ST_FULL;
        end
      end
      CMD_FREE: begin
        res_d.status = free_res.status;
        if (free_res.clr) begin
          used_d = used_q & ~NUM_BLOCKS'(MapW'(1) << free_res.idx);
        end
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= req_vld_q;
      if (req_vld_q) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

FILE: design/bba_chk.sv
// Port-level assertions for the allocator, bound to the top level.
module bba_chk
  import bba_pkg::*;
#(
  parameter int BLOCK_BYTES = DefBlockBytes
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic res_valid_o,
  input res_t res_o
);

  localparam logic [OffW-1:0] EndAdd = OffW'(BLOCK_BYTES - 1);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 res_valid_o)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, 2))
    else $error("result without a request");

  a_alloc_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_OK && $past(req_i.command, 2) == CMD_ALLOC
    |-> res_o.end_offset == res_o.start_offset + EndAdd)
    else $error("allocated block span wrong");

  a_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(req_i.command, 2) == CMD_FREE
    |-> res_o.block_index == '0 && res_o.start_offset == '0 && res_o.end_offset == '0)
    else $error("free result carries nonzero block fields");

endmodule

bind bitmap_block_allocator_core bba_chk #(.BLOCK_BYTES(BLOCK_BYTES)) u_bba_chk (.*);

FILE: tb/sv/bitmap_block_allocator_core_tb.sv
// Self-checking testbench for the bitmap block allocator: directed and random requests.
module bitmap_block_allocator_core_tb
  import bba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BlockBytes = DefBlockBytes;
  localparam int NumBlocks  = DefNumBlocks;
  localparam int NumItems   = 1350;
  localparam int DrainCycles = 6;

  class pool_shadow;
    logic [MapW-1:0] used_blocks;
    res_t            pending_results[$];
    int              mismatches;
    int              errors;

    function new();
      used_blocks = '0;
      mismatches  = 0;
      errors      = 0;
    endfunction

    function res_t predict_pool_result(req_t r);
      res_t            res;
      logic [MapW-1:0] avail;
      logic [MapW-1:0] mask;
      logic [63:0]     first_byte;
      logic [15:0]     raw;
      logic [16:0]     mag;
      int              idx;
      int              i;
      res = '0;
      res.status = ST_OK;
      if (r.command == CMD_ALLOC) begin
        mask  = (NumBlocks >= 64) ? '1 : ((64'd1 << NumBlocks) - 64'd1);
        avail = ~used_blocks & mask;
        if (avail == '0) begin
          res.status = ST_FULL;
        end else begin
          i = 0;
          while (!avail[i]) i++;
          used_blocks[i]   = 1'b1;
          first_byte       = 64'(i) * 64'(BlockBytes);
          res.block_index  = i[IdxW-1:0];
          res.start_offset = first_byte[OffW-1:0];
          res.end_offset   = OffW'(first_byte + 64'(BlockBytes) - 64'd1);
        end
      end else begin
        raw = r.free_offset;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        idx = int'(mag) / BlockBytes;
        if (!r.range_present) begin
          res.status = ST_NULL;
        end else if (int'(mag) % BlockBytes != 0) begin
          res.status = ST_MISALIGNED;
        end else if (raw[15] || idx >= NumBlocks) begin
          res.status = ST_RANGE;
        end else if (!used_blocks[idx]) begin
          res.status = ST_NOT_ALLOC;
        end else begin
          used_blocks[idx] = 1'b0;
        end
      end
      return res;
    endfunction

    function void take_request(req_t r);
      pending_results.push_back(predict_pool_result(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result status=%0d idx=%0d start=%0h end=%0h",
                   $realtime, got.status, got.block_index, got.start_offset,
                   got.end_offset);
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status || got.block_index != want.block_index ||
          got.start_offset != want.start_offset || got.end_offset != want.end_offset) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp status=%0d idx=%0d start=%0h end=%0h, ",
                   $realtime, want.status, want.block_index, want.start_offset,
                   want.end_offset,
                   "got status=%0d idx=%0d start=%0h end=%0h",
                   got.status, got.block_index, got.start_offset, got.end_offset);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  pool_shadow shadow = new();
  bit         no_gaps;

  bitmap_block_allocator_core #(
    .BLOCK_BYTES(BlockBytes),
    .NUM_BLOCKS (NumBlocks)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) shadow.take_request(req_i);
    if (rst_ni && res_valid_o) shadow.check_result(res_o);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic send_alloc();
    req_t r;
    r.command       = CMD_ALLOC;
    r.free_offset   = 16'($urandom);
    r.range_present = 1'($urandom);
    send_request(r);
  endtask

  task automatic send_free(logic [15:0] offset, logic present);
    req_t r;
    r.command       = CMD_FREE;
    r.free_offset   = offset;
    r.range_present = present;
    send_request(r);
  endtask

  function automatic logic [15:0] pick_used_offset();
    int idx;
    idx = $urandom_range(0, NumBlocks - 1);
    for (int k = 0; k < 8 && !shadow.used_blocks[idx]; k++)
      idx = $urandom_range(0, NumBlocks - 1);
    return 16'(idx * BlockBytes);
  endfunction

  task automatic send_random(int alloc_pct);
    int kind;
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_alloc();
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < 70)
        send_free(pick_used_offset(), 1'b1);
      else if (kind < 80)
        send_free(16'($urandom), 1'b0);
      else if (kind < 90)
        send_free(16'($urandom), 1'b1);
      else if (kind < 95)
        send_free(16'($urandom_range(NumBlocks, 511) * BlockBytes), 1'b1);
      else
        send_free(16'(-($urandom_range(1, 512) * BlockBytes)), 1'b1);
    end
  endtask

  initial begin
    int alloc_pct;
    int sent;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    no_gaps = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_alloc();
    send_alloc();
    send_free(16'd0, 1'b1);
    send_free(16'd0, 1'b1);
    send_free(16'd64, 1'b0);
    send_free(16'h0000, 1'b0);
    send_free(16'hFFFF, 1'b0);
    send_free(16'd1, 1'b1);
    send_free(16'd63, 1'b1);
    send_free(16'hFFFF, 1'b1);
    send_free(16'hFFC0, 1'b1);
    send_free(16'h8000, 1'b1);
    send_free(16'h7FFF, 1'b1);
    send_free(16'h7FC0, 1'b1);
    send_free(16'(NumBlocks * BlockBytes), 1'b1);
    send_free(16'((NumBlocks - 1) * BlockBytes), 1'b1);
    send_free(16'd64, 1'b1);
    send_free(16'd128, 1'b1);
    no_gaps = 1'b1;
    send_alloc();
    send_alloc();
    send_free(16'd64, 1'b1);
    send_alloc();
    send_free(16'd64, 1'b1);
    send_free(16'd0, 1'b1);

    sent = 0;
    while (sent < NumItems) begin
      case ($urandom_range(0, 2))
        0:       alloc_pct = 90;
        1:       alloc_pct = 50;
        default: alloc_pct = 15;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 150 && sent < NumItems; k++) begin
        send_random(alloc_pct);
        sent++;
      end
    end
    start = 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
